// ===== design/tcc_pkg.sv =====
package tcc_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam int CURSOR_W = 11;
   localparam int CODE_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = CODE_W + ATTR_W;
   localparam int WHERE_W  = 11;

   localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'd42;
   localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd127;
   localparam logic [CODE_W-1:0] SPACE_BYTE     = 8'h20;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR,
      DP_MOVE,
      DP_FILL,
      DP_READ,
      DP_NEWLINE,
      DP_PRINT,
      DP_BS_RD,
      DP_BS_WR,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      req_ready;
   } tcc_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_read;
      logic is_newline;
      logic is_backspace;
      logic past_end;
      logic cursor_zero;
      logic move_last;
      logic cnt_last;
      logic out_free;
   } tcc_status_type;

endpackage

// ===== design/tcc_if.sv =====
interface tcc_req_if;
   import tcc_pkg::*;

   logic                valid;
   logic                ready;
   logic                operation;
   logic [CODE_W-1:0]   char_code;
   logic [WHERE_W-1:0]  read_cell;

   modport source (output valid, operation, char_code, read_cell, input ready);
   modport sink   (input valid, operation, char_code, read_cell, output ready);
endinterface

interface tcc_rsp_if;
   import tcc_pkg::*;

   logic                valid;
   logic                ready;
   logic [CURSOR_W-1:0] cursor_cell;
   logic                scrolled;
   logic [CODE_W-1:0]   cell_char;
   logic [ATTR_W-1:0]   cell_attr;

   modport source (output valid, cursor_cell, scrolled, cell_char, cell_attr, input ready);
   modport sink   (input valid, cursor_cell, scrolled, cell_char, cell_attr, output ready);
endinterface

// ===== design/tcc_datapath.sv =====
module tcc_datapath #(
   parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   tcc_req_if.sink                        req,
   tcc_rsp_if.source                      rsp,
   input  logic                           csr_wr_en,
   input  logic [tcc_pkg::ATTR_W-1:0]     csr_wr_data,
   input  tcc_pkg::tcc_cmd_type           cmd,
   output tcc_pkg::tcc_status_type        status
);
   import tcc_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CUR_W      = $clog2(CELL_COUNT + 1);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int CMP_W      = (CUR_W > WHERE_W) ? CUR_W : WHERE_W;

   // screen memory, one cell per entry
   logic [CELL_W-1:0]   screen_ff [CELL_COUNT];
   logic [CELL_W-1:0]   rd_data_ff;

   logic [CUR_W-1:0]    cursor_ff, cursor_in;
   logic [CUR_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;
   logic                mv_pend_ff;
   logic [ADDR_W-1:0]   mv_addr_ff;
   logic                scrolled_ff, scrolled_in;
   logic [ATTR_W-1:0]   attribute_ff;
   logic                rsp_valid_ff;

   logic                op_ff;
   logic [CODE_W-1:0]   code_ff;
   logic [CMP_W-1:0]    where_ff;
   logic                hit_ff;

   logic [CURSOR_W-1:0] out_cursor_ff;
   logic                out_scrolled_ff;
   logic [CODE_W-1:0]   out_char_ff;
   logic [ATTR_W-1:0]   out_attr_ff;

   logic                accept;
   logic                where_hit;
   logic                cnt_last;
   logic                wr_en, rd_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [CELL_W-1:0]   wr_data;
   logic [ADDR_W-1:0]   cursor_addr;

   assign accept      = req.valid && req.ready;
   assign req.ready   = cmd.req_ready;
   assign where_hit   = where_ff < CMP_W'(CELL_COUNT);
   assign cnt_last    = cnt_ff == ADDR_W'(CELL_COUNT - 1);
   assign cursor_addr = cursor_ff[ADDR_W-1:0];

   assign status.req_valid    = req.valid;
   assign status.is_read      = op_ff == OP_READ;
   assign status.is_newline   = code_ff == CODE_NEWLINE;
   assign status.is_backspace = code_ff == CODE_BACKSPACE;
   assign status.past_end     = cursor_ff == CUR_W'(CELL_COUNT);
   assign status.cursor_zero  = cursor_ff == '0;
   assign status.move_last    = cnt_ff == ADDR_W'(CELL_COUNT - COLUMNS - 1);
   assign status.cnt_last     = cnt_last;
   assign status.out_free     = !rsp_valid_ff || rsp.ready;

   // memory port selection; a command's own write overrides the delayed write of a row move
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = cnt_ff + ADDR_W'(COLUMNS);
      if (mv_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = mv_addr_ff;
         wr_data = rd_data_ff;
      end
      unique case (cmd.op)
         DP_CLEAR: begin
            wr_en = 1'b1;
         end
         DP_FILL: begin
            wr_en   = 1'b1;
            wr_data = {SPACE_BYTE, SPACE_BYTE};
         end
         DP_PRINT: begin
            wr_en   = 1'b1;
            wr_addr = cursor_addr;
            wr_data = {attribute_ff, code_ff};
         end
         DP_BS_WR: begin
            wr_en   = 1'b1;
            wr_addr = cursor_addr;
            wr_data = {rd_data_ff[CELL_W-1:CODE_W], SPACE_BYTE};
         end
         DP_MOVE: begin
            rd_en = 1'b1;
         end
         DP_READ: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(where_ff);
         end
         DP_BS_RD: begin
            rd_en   = 1'b1;
            rd_addr = cursor_addr - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= screen_ff[rd_addr];
      end
   end

   always_comb begin
      cursor_in   = cursor_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      cnt_in      = cnt_ff;
      scrolled_in = scrolled_ff;
      if (accept) begin
         scrolled_in = 1'b0;
      end
      unique case (cmd.op)
         DP_CLEAR, DP_MOVE: begin
            cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
         end
         DP_FILL: begin
            cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
            if (cnt_last) begin
               cursor_in   = CUR_W'(CELL_COUNT - COLUMNS);
               row_in      = CUR_W'(CELL_COUNT - COLUMNS);
               col_in      = '0;
               scrolled_in = 1'b1;
            end
         end
         DP_NEWLINE: begin
            cursor_in = row_ff + CUR_W'(COLUMNS);
            row_in    = row_ff + CUR_W'(COLUMNS);
            col_in    = '0;
         end
         DP_PRINT: begin
            cursor_in = cursor_ff + 1'b1;
            if (col_ff == COL_W'(COLUMNS - 1)) begin
               col_in = '0;
               row_in = row_ff + CUR_W'(COLUMNS);
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         DP_BS_RD: begin
            cursor_in = cursor_ff - 1'b1;
            if (col_ff == '0) begin
               col_in = COL_W'(COLUMNS - 1);
               row_in = row_ff - CUR_W'(COLUMNS);
            end else begin
               col_in = col_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         mv_pend_ff   <= 1'b0;
         scrolled_ff  <= 1'b0;
         attribute_ff <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff   <= cursor_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         cnt_ff      <= cnt_in;
         mv_pend_ff  <= cmd.op == DP_MOVE;
         scrolled_ff <= scrolled_in;
         if (csr_wr_en) begin
            attribute_ff <= csr_wr_data;
         end
         if (cmd.op == DP_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mv_addr_ff <= cnt_ff;
      if (accept) begin
         op_ff    <= req.operation;
         code_ff  <= req.char_code;
         where_ff <= CMP_W'(req.read_cell);
      end
      if (cmd.op == DP_READ) begin
         hit_ff <= where_hit;
      end
      if (cmd.op == DP_RESULT) begin
         out_cursor_ff   <= CURSOR_W'(cursor_ff);
         out_scrolled_ff <= scrolled_ff;
         if (op_ff == OP_READ && hit_ff) begin
            out_char_ff <= rd_data_ff[CODE_W-1:0];
            out_attr_ff <= rd_data_ff[CELL_W-1:CODE_W];
         end else begin
            out_char_ff <= '0;
            out_attr_ff <= '0;
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.cursor_cell = out_cursor_ff;
   assign rsp.scrolled    = out_scrolled_ff;
   assign rsp.cell_char   = out_char_ff;
   assign rsp.cell_attr   = out_attr_ff;

endmodule

// ===== design/tcc_control.sv =====
module tcc_control (
   input  logic                    clock,
   input  logic                    reset,
   input  tcc_pkg::tcc_status_type status,
   output tcc_pkg::tcc_cmd_type    cmd
);
   import tcc_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WORK,
      ST_MOVE,
      ST_DRAIN,
      ST_FILL,
      ST_BS_WR,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.op        = DP_NOP;
      cmd.req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (status.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            priority if (status.is_read) begin
               cmd.op   = DP_READ;
               state_in = ST_RESULT;
            end else if (status.past_end) begin
               state_in = ST_MOVE;
            end else if (status.is_newline) begin
               cmd.op   = DP_NEWLINE;
               state_in = ST_RESULT;
            end else if (status.is_backspace) begin
               if (!status.cursor_zero) begin
                  cmd.op   = DP_BS_RD;
                  state_in = ST_BS_WR;
               end else begin
                  state_in = ST_RESULT;
               end
            end else begin
               cmd.op   = DP_PRINT;
               state_in = ST_RESULT;
            end
         end
         ST_MOVE: begin
            cmd.op = DP_MOVE;
            if (status.move_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last moved cell is written this cycle
            state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.op = DP_FILL;
            if (status.cnt_last) begin
               state_in = ST_WORK;
            end
         end
         ST_BS_WR: begin
            cmd.op   = DP_BS_WR;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.op   = DP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/text_console_cursor_scroll.sv =====
// Channel  Dir  Handshake    Payload
// req      in   valid/ready  operation, char_code, read_cell
// rsp      out  valid/ready  cursor_cell, scrolled, cell_char, cell_attr
// csr      in   csr_wr_en    csr_wr_data (attribute byte)
//
// A backspace reads the cell before the cursor and then rewrites its character
// as a space; at cell zero it does neither.
// A put at the past-end cursor first scrolls: row moves through the screen
// memory's read and write ports, a drain state, a fill of the bottom row with
// spaces and then a new decode of the item.
// After reset a clearing pass zeroes every cell of the screen before the
// first item is taken. A stalled rsp holds one finished item while the
// next item is accepted and worked on.
module text_console_cursor_scroll #(
   parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
   input  logic                       clock,
   input  logic                       reset,
   tcc_req_if.sink                    req,
   tcc_rsp_if.source                  rsp,
   input  logic                       csr_wr_en,
   input  logic [tcc_pkg::ATTR_W-1:0] csr_wr_data
);
   import tcc_pkg::*;

   tcc_cmd_type    cmd;
   tcc_status_type status;

   tcc_control u_control (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   tcc_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== tb/tb_text_console_cursor_scroll.sv =====
localparam int SCREEN_COLS  = tcc_pkg::DEF_COLUMNS;
localparam int SCREEN_CELLS = tcc_pkg::DEF_ROWS * tcc_pkg::DEF_COLUMNS;

typedef struct packed {
   logic [tcc_pkg::CURSOR_W-1:0] cursor_cell;
   logic                         scrolled;
   logic [tcc_pkg::CODE_W-1:0]   cell_char;
   logic [tcc_pkg::ATTR_W-1:0]   cell_attr;
} console_result_type;

class console_scoreboard;
   logic [tcc_pkg::CELL_W-1:0] screen [SCREEN_CELLS];
   int unsigned                cursor;
   logic [tcc_pkg::ATTR_W-1:0] attribute;
   console_result_type         expected_q[$];
   int                         mismatches;

   function new();
      for (int k = 0; k < SCREEN_CELLS; k++) screen[k] = '0;
      cursor = 0;
      attribute = tcc_pkg::ATTR_RESET;
      mismatches = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Update screen and cursor for one accepted item and queue its result.
   function void note_item(logic op, logic [tcc_pkg::CODE_W-1:0] code,
                           logic [tcc_pkg::WHERE_W-1:0] where_idx);
      console_result_type r;
      r = '0;
      if (op == tcc_pkg::OP_PUT) begin
         if (cursor >= SCREEN_CELLS) begin
            for (int k = 0; k < SCREEN_CELLS - SCREEN_COLS; k++)
               screen[k] = screen[k + SCREEN_COLS];
            for (int k = SCREEN_CELLS - SCREEN_COLS; k < SCREEN_CELLS; k++)
               screen[k] = {tcc_pkg::SPACE_BYTE, tcc_pkg::SPACE_BYTE};
            cursor = SCREEN_CELLS - SCREEN_COLS;
            r.scrolled = 1'b1;
         end
         if (code == tcc_pkg::CODE_NEWLINE) begin
            cursor = (cursor / SCREEN_COLS + 1) * SCREEN_COLS;
         end else if (code == tcc_pkg::CODE_BACKSPACE) begin
            if (cursor > 0) begin
               cursor--;
               screen[cursor][7:0] = tcc_pkg::SPACE_BYTE;
            end
         end else begin
            screen[cursor] = {attribute, code};
            cursor++;
         end
      end else if (where_idx < SCREEN_CELLS) begin
         r.cell_char = screen[where_idx][7:0];
         r.cell_attr = screen[where_idx][15:8];
      end
      r.cursor_cell = cursor[10:0];
      expected_q.push_back(r);
   endfunction

   function void check_result(console_result_type got);
      console_result_type want;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected item: cursor=%0d scrolled=%0d char=%02h attr=%02h",
                     got.cursor_cell, got.scrolled, got.cell_char, got.cell_attr);
      end else begin
         want = expected_q.pop_front();
         if (got.cursor_cell !== want.cursor_cell || got.scrolled !== want.scrolled ||
             got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: cursor exp %0d got %0d, scrolled exp %0d got %0d, ",
                         "char exp %02h got %02h, attr exp %02h got %02h"},
                        want.cursor_cell, got.cursor_cell, want.scrolled, got.scrolled,
                        want.cell_char, got.cell_char, want.cell_attr, got.cell_attr);
         end
      end
   endfunction
endclass

module tb_text_console_cursor_scroll;
   import tcc_pkg::*;

   localparam int QUIET_LIMIT = 10000;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ATTR_W-1:0] csr_wr_data;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   console_scoreboard sb = new();

   tcc_req_if req_if ();
   tcc_rsp_if rsp_if ();

   text_console_cursor_scroll dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result({rsp_if.cursor_cell, rsp_if.scrolled,
                             rsp_if.cell_char, rsp_if.cell_attr});
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // covers the clearing pass after reset and a full scroll
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic op, input logic [CODE_W-1:0] code,
                            input logic [WHERE_W-1:0] where_idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.char_code <= code;
      req_if.read_cell <= where_idx;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_item(op, code, where_idx);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Text-like traffic: short lines, frequent newlines so the screen scrolls often,
   // now and then a long unbroken line that wraps and runs off the bottom row.
   task automatic run_text(input int count);
      int n;
      int pick;
      int burst;
      logic [CODE_W-1:0] code;
      logic [WHERE_W-1:0] where_idx;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            burst = $urandom_range(100, 60);
            for (int k = 0; k < burst; k++) begin
               code = CODE_W'($urandom_range(255));
               if (code == CODE_NEWLINE || code == CODE_BACKSPACE) code = 8'h2E;
               send_item(OP_PUT, code, WHERE_W'($urandom_range(2047)));
            end
            n += burst;
         end else begin
            if (pick < 28) begin
               case ($urandom_range(2))
                  0: where_idx = WHERE_W'($urandom_range(2047));
                  1: where_idx = WHERE_W'(sb.cursor + $urandom_range(4)) - 11'd2;
                  default: where_idx = WHERE_W'($urandom_range(SCREEN_CELLS - 1,
                                                 SCREEN_CELLS - SCREEN_COLS));
               endcase
               send_item(OP_READ, CODE_W'($urandom_range(255)), where_idx);
            end else begin
               if (pick < 50) code = CODE_NEWLINE;
               else if (pick < 58) code = CODE_BACKSPACE;
               else code = CODE_W'($urandom_range(255));
               send_item(OP_PUT, code, WHERE_W'($urandom_range(2047)));
            end
            n++;
         end
      end
   endtask

   initial begin
      int idle_plan [5];
      int stall_plan [5];
      logic [ATTR_W-1:0] attr_plan [5];

      idle_plan  = '{0, 71, 0, 30, 0};
      stall_plan = '{0, 0, 71, 30, 0};
      attr_plan  = '{ATTR_RESET, 8'hFF, 8'h00, ATTR_W'($urandom_range(255)),
                     ATTR_W'($urandom_range(255))};

      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_PUT;
      req_if.char_code <= '0;
      req_if.read_cell <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // cleared screen, out-of-range reads, backspace at cell zero, extreme codes
      send_item(OP_READ, 8'h00, 11'd0);
      send_item(OP_READ, 8'hFF, 11'd1999);
      send_item(OP_READ, 8'h00, 11'd2000);
      send_item(OP_READ, 8'hFF, 11'd2047);
      send_item(OP_PUT, CODE_BACKSPACE, 11'd0);
      send_item(OP_PUT, 8'h00, 11'd2047);
      send_item(OP_PUT, 8'hFF, 11'd0);
      send_item(OP_PUT, 8'h41, 11'd1024);
      send_item(OP_PUT, CODE_BACKSPACE, 11'd1023);
      send_item(OP_READ, 8'h55, 11'd2);
      send_item(OP_READ, 8'hAA, 11'd1);
      send_item(OP_PUT, CODE_NEWLINE, 11'd0);
      send_item(OP_PUT, 8'h0D, 11'd0);
      send_item(OP_PUT, CODE_NEWLINE, 11'd0);
      send_item(OP_PUT, CODE_BACKSPACE, 11'd0);
      send_item(OP_READ, 8'h00, 11'd159);
      send_item(OP_READ, 8'h00, 11'd80);

      for (int phase_no = 0; phase_no < 5; phase_no++) begin
         drain_results();
         if (phase_no > 0) begin
            csr_wr_en   <= 1'b1;
            csr_wr_data <= attr_plan[phase_no];
            @(posedge clock);
            csr_wr_en <= 1'b0;
            sb.attribute = attr_plan[phase_no];
         end
         send_idle_pct  = idle_plan[phase_no];
         recv_stall_pct = stall_plan[phase_no];
         run_text(217);
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
